// File: hdl/button_debounce_autorepeat_unit_assert.svh
// assertion macros shared by the debounce/autorepeat block
`ifndef BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_AUTOREPEAT_UNIT_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define BDA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("bda: same-cycle check failed");

// consequent must hold in the cycle after the antecedent
`define BDA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("bda: next-cycle check failed");

`endif

// File: hdl/bda_pkg.sv
package bda_pkg;

	// geometry
	localparam int NUM_BUTTONS = 6;
	localparam int LEVEL_BITS  = 6;
	localparam int OUT_FIELDS  = 6;
	localparam int HOLD_W      = 7;
	localparam int EVT_W       = 4;
	localparam int ADDR_W      = 4;
	localparam int DATA_W      = 32;
	localparam int REG_IDX_W   = 2;

	localparam logic [HOLD_W-1:0] HOLD_MAX = '1;

	// register reset values
	localparam logic [HOLD_W-1:0] PRESS_THRESHOLD_RST = 7'd2;
	localparam logic [HOLD_W-1:0] REPEAT_LIMIT_RST    = 7'd100;
	localparam logic [HOLD_W-1:0] REPEAT_RELOAD_RST   = 7'd80;
	localparam logic [EVT_W-1:0]  EVENT_MAX_RST       = 4'd10;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_PRESS_THRESHOLD = 2'd0,
		REG_REPEAT_LIMIT    = 2'd1,
		REG_REPEAT_RELOAD   = 2'd2,
		REG_EVENT_MAX       = 2'd3
	} reg_idx_t;

	typedef enum logic {
		OP_TICK    = 1'b0,
		OP_COLLECT = 1'b1
	} op_t;

	typedef struct packed {
		logic [HOLD_W-1:0] press_threshold;
		logic [HOLD_W-1:0] repeat_limit;
		logic [HOLD_W-1:0] repeat_reload;
		logic [EVT_W-1:0]  event_max;
	} cfg_t;

	// per-lane command for the current request
	typedef struct packed {
		logic tick;
		logic collect;
	} lane_cmd_t;

	typedef logic [NUM_BUTTONS-1:0][EVT_W-1:0] pend_t;
	typedef logic [OUT_FIELDS-1:0][EVT_W-1:0]  evt_t;

endpackage

// File: hdl/bda_if.sv
// request channel: op plus button levels
interface bda_req_if;
	logic                           valid;
	logic                           ready;
	logic                           op;
	logic [bda_pkg::LEVEL_BITS-1:0] button_levels;

	modport source (output valid, output op, output button_levels, input ready);
	modport sink (input valid, input op, input button_levels, output ready);
endinterface

// result channel: pending event counts per button
interface bda_rsp_if;
	logic                      valid;
	logic                      ready;
	logic [bda_pkg::EVT_W-1:0] events_b0;
	logic [bda_pkg::EVT_W-1:0] events_b1;
	logic [bda_pkg::EVT_W-1:0] events_b2;
	logic [bda_pkg::EVT_W-1:0] events_b3;
	logic [bda_pkg::EVT_W-1:0] events_b4;
	logic [bda_pkg::EVT_W-1:0] events_b5;

	modport source (output valid, output events_b0, output events_b1, output events_b2,
		output events_b3, output events_b4, output events_b5, input ready);
	modport sink (input valid, input events_b0, input events_b1, input events_b2,
		input events_b3, input events_b4, input events_b5, output ready);
endinterface

// File: hdl/button_debounce_autorepeat_unit.sv
// channel  dir  accepted when            payload
// req      in   req.valid && req.ready   op, button_levels
// rsp      out  rsp.valid && rsp.ready   events_b0 .. events_b5
// apb      in   psel penable pwrite      paddr, pwdata (prdata on read)
//
// one request per cycle while req.ready is high; all button lanes update in the same cycle
// a collect with events pending lands in a two-entry result buffer and
// reaches rsp once earlier results have gone; ticks and empty collects give no result
// req.ready drops only while both result entries are held by rsp stalls
// reset is asynchronous: counters clear, registers take their defaults
module button_debounce_autorepeat_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	bda_req_if.sink                     req,
	bda_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bda_pkg::ADDR_W-1:0]  paddr,
	input  logic [bda_pkg::DATA_W-1:0]  pwdata,
	output logic [bda_pkg::DATA_W-1:0]  prdata,
	output logic                        pready
);

	bda_pkg::cfg_t      cfg;
	bda_pkg::lane_cmd_t cmd;
	bda_pkg::pend_t     pend;
	bda_pkg::evt_t      evt;
	logic               fire;

	bda_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// decode the accepted request
	assign fire        = req.valid && req.ready;
	assign cmd.tick    = fire && (bda_pkg::op_t'(req.op) == bda_pkg::OP_TICK);
	assign cmd.collect = fire && (bda_pkg::op_t'(req.op) == bda_pkg::OP_COLLECT);

	// one lane per button, buttons without an input bit read released
	for (genvar i = 0; i < bda_pkg::NUM_BUTTONS; i++) begin : g_lane
		logic level;
		if (i < bda_pkg::LEVEL_BITS) begin : g_in
			assign level = req.button_levels[i];
		end else begin : g_none
			assign level = 1'b1;
		end

		bda_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.cfg    (cfg),
			.cmd    (cmd),
			.level  (level),
			.pend   (pend[i])
		);
	end

	bda_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.collect   (cmd.collect),
		.pend      (pend),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.out_evt   (evt)
	);

	assign rsp.events_b0 = evt[0];
	assign rsp.events_b1 = evt[1];
	assign rsp.events_b2 = evt[2];
	assign rsp.events_b3 = evt[3];
	assign rsp.events_b4 = evt[4];
	assign rsp.events_b5 = evt[5];

endmodule

// File: hdl/bda_cfg.sv
module bda_cfg (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [bda_pkg::ADDR_W-1:0]   paddr,
	input  logic [bda_pkg::DATA_W-1:0]   pwdata,
	output logic [bda_pkg::DATA_W-1:0]   prdata,
	output logic                         pready,
	output bda_pkg::cfg_t                cfg
);

	bda_pkg::cfg_t     cfg_q;
	bda_pkg::reg_idx_t idx;
	logic              wr_en;

	// word address selects the register
	assign idx    = bda_pkg::reg_idx_t'(paddr[bda_pkg::ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.press_threshold <= bda_pkg::PRESS_THRESHOLD_RST;
			cfg_q.repeat_limit    <= bda_pkg::REPEAT_LIMIT_RST;
			cfg_q.repeat_reload   <= bda_pkg::REPEAT_RELOAD_RST;
			cfg_q.event_max       <= bda_pkg::EVENT_MAX_RST;
		end else if (wr_en) begin
			unique case (idx)
				bda_pkg::REG_PRESS_THRESHOLD: begin
					cfg_q.press_threshold <= pwdata[bda_pkg::HOLD_W-1:0];
				end
				bda_pkg::REG_REPEAT_LIMIT: begin
					cfg_q.repeat_limit <= pwdata[bda_pkg::HOLD_W-1:0];
				end
				bda_pkg::REG_REPEAT_RELOAD: begin
					cfg_q.repeat_reload <= pwdata[bda_pkg::HOLD_W-1:0];
				end
				bda_pkg::REG_EVENT_MAX: begin
					cfg_q.event_max <= pwdata[bda_pkg::EVT_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// readback
	always_comb begin
		prdata = '0;
		unique case (idx)
			bda_pkg::REG_PRESS_THRESHOLD: begin
				prdata[bda_pkg::HOLD_W-1:0] = cfg_q.press_threshold;
			end
			bda_pkg::REG_REPEAT_LIMIT: begin
				prdata[bda_pkg::HOLD_W-1:0] = cfg_q.repeat_limit;
			end
			bda_pkg::REG_REPEAT_RELOAD: begin
				prdata[bda_pkg::HOLD_W-1:0] = cfg_q.repeat_reload;
			end
			bda_pkg::REG_EVENT_MAX: begin
				prdata[bda_pkg::EVT_W-1:0] = cfg_q.event_max;
			end
			default: begin
			end
		endcase
	end

endmodule

// File: hdl/bda_lane.sv
`include "button_debounce_autorepeat_unit_assert.svh"

module bda_lane (
	input  logic                       clk,
	input  logic                       arst_n,
	input  bda_pkg::cfg_t              cfg,
	input  bda_pkg::lane_cmd_t         cmd,
	input  logic                       level,
	output logic [bda_pkg::EVT_W-1:0]  pend
);

	logic [bda_pkg::HOLD_W-1:0] hold_q, hold_d, h_inc, h_rep;
	logic [bda_pkg::EVT_W-1:0]  pend_q, pend_d, p_rep, p_thr;
	logic                       pressed, rep, thr;

	assign pend = pend_q;

	// hold counter step: increment, repeat reload, then threshold compare
	always_comb begin
		pressed = !level;
		h_inc   = (hold_q < bda_pkg::HOLD_MAX) ? hold_q + 1'b1 : hold_q;
		rep     = h_inc > cfg.repeat_limit;
		h_rep   = rep ? cfg.repeat_reload : h_inc;
		p_rep   = (rep && (pend_q < cfg.event_max)) ? pend_q + 1'b1 : pend_q;
		thr     = h_rep == cfg.press_threshold;
		p_thr   = (thr && (p_rep < cfg.event_max)) ? p_rep + 1'b1 : p_rep;

		hold_d = hold_q;
		pend_d = pend_q;
		if (cmd.tick) begin
			hold_d = pressed ? h_rep : '0;
			pend_d = pressed ? p_thr : pend_q;
		end
		// collect clears the count, a no-op when nothing is pending
		if (cmd.collect) begin
			pend_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= '0;
			pend_q <= '0;
		end else begin
			hold_q <= hold_d;
			pend_q <= pend_d;
		end
	end

	`BDA_ASSERT_NEXT(a_release_clears, clk, arst_n, cmd.tick && level, hold_q == '0)
	`BDA_ASSERT_NEXT(a_collect_clears, clk, arst_n, cmd.collect, pend_q == '0)
	`BDA_ASSERT_NEXT(a_collect_keeps_hold, clk, arst_n, cmd.collect, hold_q == $past(hold_q))

endmodule

// File: hdl/bda_merge.sv
`include "button_debounce_autorepeat_unit_assert.svh"

module bda_merge (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  collect,
	input  bda_pkg::pend_t        pend,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output bda_pkg::evt_t         out_evt
);

	bda_pkg::evt_t evt;
	logic          any, push, pop;
	logic          out_vld_q, skid_vld_q;
	bda_pkg::evt_t out_q, skid_q;

	// gather lane counts into the result fields, unused fields read zero
	always_comb begin
		evt = '0;
		any = 1'b0;
		for (int i = 0; i < bda_pkg::NUM_BUTTONS; i++) begin
			any = any || (pend[i] != '0);
			if (i < bda_pkg::OUT_FIELDS) begin
				evt[i] = pend[i];
			end
		end
	end

	assign push      = collect && any;
	assign pop       = out_vld_q && out_ready;
	assign in_ready  = !skid_vld_q;
	assign out_valid = out_vld_q;
	assign out_evt   = out_q;

	// two-entry result buffer: output register plus skid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			out_vld_q  <= skid_vld_q || push;
			skid_vld_q <= skid_vld_q && push;
		end else if (push) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			out_q <= skid_vld_q ? skid_q : evt;
			if (skid_vld_q) begin
				skid_q <= evt;
			end
		end else if (push) begin
			skid_q <= evt;
		end
	end

	`BDA_ASSERT_SAME(a_skid_behind_out, clk, arst_n, skid_vld_q, out_vld_q)
	`BDA_ASSERT_SAME(a_push_has_room, clk, arst_n, push, !skid_vld_q)
	`BDA_ASSERT_NEXT(a_push_shows, clk, arst_n, push, out_vld_q)

endmodule

// File: tb/tb_button_debounce_autorepeat_unit.sv
module tb_button_debounce_autorepeat_unit;
	import bda_pkg::*;

	// what a directed row says about its own result
	typedef struct {
		bit   typed;
		bit   has;
		evt_t counts;
	} row_mark_t;

	typedef struct {
		bit                    is_cfg;
		reg_idx_t              idx;
		logic [HOLD_W-1:0]     value;
		op_t                   op;
		logic [LEVEL_BITS-1:0] levels;
		row_mark_t             mark;
	} dir_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	bda_req_if req_ch ();
	bda_rsp_if rsp_ch ();

	button_debounce_autorepeat_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req_ch),
		.rsp     (rsp_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// predictor state
	cfg_t              cfg_model;
	logic [HOLD_W-1:0] hold_model [NUM_BUTTONS];
	logic [EVT_W-1:0]  pend_model [NUM_BUTTONS];

	evt_t      counts_due [$];
	row_mark_t row_marks [$];
	dir_row_t  dir_tab [$];
	row_mark_t no_mark;
	int        mismatches;
	bit        calm;
	int        stall_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	task automatic report(string msg);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] mismatch: %s", $time, msg);
	endtask

	// saturating event count for one button
	function automatic void count_event(int b);
		if (pend_model[b] < cfg_model.event_max)
			pend_model[b] = pend_model[b] + 1'b1;
	endfunction

	// one request: tick advances hold counters, collect reports and clears
	function automatic bit debounce_step(op_t op, logic [LEVEL_BITS-1:0] levels,
		output evt_t counts);
		int b;
		bit any;
		counts = '0;
		any = 1'b0;
		if (op == OP_TICK) begin
			for (b = 0; b < NUM_BUTTONS; b++) begin
				if (levels[b]) begin
					hold_model[b] = '0;
				end else begin
					if (hold_model[b] < HOLD_MAX)
						hold_model[b] = hold_model[b] + 1'b1;
					// repeat test comes before the press compare
					if (hold_model[b] > cfg_model.repeat_limit) begin
						hold_model[b] = cfg_model.repeat_reload;
						count_event(b);
					end
					if (hold_model[b] == cfg_model.press_threshold)
						count_event(b);
				end
			end
			return 1'b0;
		end
		for (b = 0; b < NUM_BUTTONS; b++)
			if (pend_model[b] != '0)
				any = 1'b1;
		if (!any)
			return 1'b0;
		for (b = 0; b < NUM_BUTTONS; b++) begin
			counts[b] = pend_model[b];
			pend_model[b] = '0;
		end
		return 1'b1;
	endfunction

	// request and result monitor
	always @(posedge clk) begin : watch
		row_mark_t mark;
		evt_t      counts;
		evt_t      got;
		bit        has;
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				has = debounce_step(op_t'(req_ch.op), req_ch.button_levels, counts);
				mark = no_mark;
				if (row_marks.size() != 0)
					mark = row_marks.pop_front();
				if (mark.typed) begin
					has = mark.has;
					counts = mark.counts;
				end
				if (has)
					counts_due.push_back(counts);
			end
			if (rsp_ch.valid && rsp_ch.ready) begin
				got = {rsp_ch.events_b5, rsp_ch.events_b4, rsp_ch.events_b3,
					rsp_ch.events_b2, rsp_ch.events_b1, rsp_ch.events_b0};
				if (counts_due.size() == 0) begin
					report($sformatf("result %h with no collect waiting", got));
				end else begin
					counts = counts_due.pop_front();
					for (int b = 0; b < OUT_FIELDS; b++)
						if (got[b] !== counts[b])
							report($sformatf("events_b%0d got %0d want %0d",
								b, got[b], counts[b]));
				end
			end
		end
	end

	// result side stalls
	initial begin
		rsp_ch.ready = 1'b0;
		stall_left = 0;
		forever begin
			@(posedge clk);
			if (calm) begin
				rsp_ch.ready <= 1'b1;
			end else if (stall_left > 0) begin
				rsp_ch.ready <= 1'b0;
				stall_left--;
			end else if ($urandom_range(0, 99) < 8) begin
				rsp_ch.ready <= 1'b0;
				stall_left = $urandom_range(0, 3);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// one request, sometimes with a random gap ahead of it
	task automatic send_request(op_t op, logic [LEVEL_BITS-1:0] levels, row_mark_t mark);
		if (!calm && $urandom_range(0, 99) < 11) begin
			req_ch.valid <= 1'b0;
			req_ch.op <= 1'($urandom);
			req_ch.button_levels <= LEVEL_BITS'($urandom);
			repeat ($urandom_range(1, 3)) @(posedge clk);
		end
		row_marks.push_back(mark);
		req_ch.valid <= 1'b1;
		req_ch.op <= op;
		req_ch.button_levels <= levels;
		do @(posedge clk); while (!req_ch.ready);
	endtask

	// stop sending until every result is in, then let the pipe settle
	task automatic drain();
		req_ch.valid <= 1'b0;
		do @(posedge clk); while (counts_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic apb_idle();
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// write one register with junk above the field, then read it back
	task automatic reg_write(reg_idx_t idx, logic [HOLD_W-1:0] value);
		logic [DATA_W-1:0] word;
		logic [DATA_W-1:0] want;
		word = $urandom;
		if (idx == REG_EVENT_MAX)
			word[EVT_W-1:0] = value[EVT_W-1:0];
		else
			word[HOLD_W-1:0] = value;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= word;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			REG_PRESS_THRESHOLD: cfg_model.press_threshold = word[HOLD_W-1:0];
			REG_REPEAT_LIMIT:    cfg_model.repeat_limit = word[HOLD_W-1:0];
			REG_REPEAT_RELOAD:   cfg_model.repeat_reload = word[HOLD_W-1:0];
			REG_EVENT_MAX:       cfg_model.event_max = word[EVT_W-1:0];
		endcase
		// read back
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		want = '0;
		case (idx)
			REG_PRESS_THRESHOLD: want[HOLD_W-1:0] = cfg_model.press_threshold;
			REG_REPEAT_LIMIT:    want[HOLD_W-1:0] = cfg_model.repeat_limit;
			REG_REPEAT_RELOAD:   want[HOLD_W-1:0] = cfg_model.repeat_reload;
			REG_EVENT_MAX:       want[EVT_W-1:0] = cfg_model.event_max;
		endcase
		if (prdata !== want)
			report($sformatf("register %s read %h want %h", idx.name(), prdata, want));
	endtask

	function automatic dir_row_t item_row(op_t op, logic [LEVEL_BITS-1:0] levels);
		dir_row_t r;
		r.is_cfg = 1'b0;
		r.idx = REG_PRESS_THRESHOLD;
		r.value = '0;
		r.op = op;
		r.levels = levels;
		r.mark = no_mark;
		return r;
	endfunction

	function automatic dir_row_t collect_row(logic [LEVEL_BITS-1:0] levels, bit has,
		evt_t counts);
		dir_row_t r;
		r = item_row(OP_COLLECT, levels);
		r.mark.typed = 1'b1;
		r.mark.has = has;
		r.mark.counts = counts;
		return r;
	endfunction

	function automatic dir_row_t cfg_row(reg_idx_t idx, logic [HOLD_W-1:0] value);
		dir_row_t r;
		r = item_row(OP_TICK, '1);
		r.is_cfg = 1'b1;
		r.idx = idx;
		r.value = value;
		return r;
	endfunction

	// random requests under one register setting
	task automatic run_phase(logic [HOLD_W-1:0] thr, logic [HOLD_W-1:0] lim,
		logic [HOLD_W-1:0] rel, logic [EVT_W-1:0] emax, int quota);
		int sent;
		int n;
		int pick;
		logic [LEVEL_BITS-1:0] base;
		logic [LEVEL_BITS-1:0] levels;
		sent = 0;
		drain();
		reg_write(REG_PRESS_THRESHOLD, thr);
		reg_write(REG_REPEAT_LIMIT, lim);
		reg_write(REG_REPEAT_RELOAD, rel);
		reg_write(REG_EVENT_MAX, 7'(emax));
		apb_idle();
		while (sent < quota) begin
			pick = $urandom_range(0, 99);
			if (pick < 12) begin
				// noise: any op, any levels
				repeat ($urandom_range(1, 4)) begin
					send_request(op_t'($urandom_range(0, 1)), LEVEL_BITS'($urandom), no_mark);
					sent++;
				end
			end else begin
				// hold a button pattern, then usually collect
				base = LEVEL_BITS'($urandom);
				pick = $urandom_range(0, 99);
				n = (pick < 80) ? $urandom_range(1, 24) :
					(pick < 92) ? $urandom_range(25, 60) : $urandom_range(100, 150);
				repeat (n) begin
					levels = base;
					// contact bounce on one button
					if ($urandom_range(0, 99) < 8)
						levels[$urandom_range(0, LEVEL_BITS - 1)] ^= 1'b1;
					send_request(OP_TICK, levels, no_mark);
					sent++;
				end
				if ($urandom_range(0, 99) < 85) begin
					send_request(OP_COLLECT, LEVEL_BITS'($urandom), no_mark);
					sent++;
				end
				if ($urandom_range(0, 99) < 10) begin
					send_request(OP_COLLECT, LEVEL_BITS'($urandom), no_mark);
					sent++;
				end
			end
		end
	endtask

	initial begin
		bit in_cfg;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = 1'b0;
		req_ch.button_levels = '0;
		mismatches = 0;
		calm = 1'b0;
		in_cfg = 1'b0;
		no_mark = '{typed: 1'b0, has: 1'b0, counts: '0};
		cfg_model = '{press_threshold: PRESS_THRESHOLD_RST, repeat_limit: REPEAT_LIMIT_RST,
			repeat_reload: REPEAT_RELOAD_RST, event_max: EVENT_MAX_RST};
		for (int b = 0; b < NUM_BUTTONS; b++) begin
			hold_model[b] = '0;
			pend_model[b] = '0;
		end

		// directed rows: reset defaults, then reload equal to threshold, saturation
		dir_tab.push_back(collect_row(6'h00, 1'b0, '0));
		dir_tab.push_back(item_row(OP_TICK, 6'h3f));
		dir_tab.push_back(item_row(OP_TICK, 6'h00));
		dir_tab.push_back(item_row(OP_TICK, 6'h00));
		dir_tab.push_back(collect_row(6'h3f, 1'b1, 24'h111111));
		dir_tab.push_back(collect_row(6'h00, 1'b0, '0));
		dir_tab.push_back(item_row(OP_TICK, 6'h2a));
		dir_tab.push_back(item_row(OP_TICK, 6'h15));
		dir_tab.push_back(item_row(OP_TICK, 6'h15));
		dir_tab.push_back(collect_row(6'h2a, 1'b1, 24'h101010));
		dir_tab.push_back(cfg_row(REG_PRESS_THRESHOLD, 7'd1));
		dir_tab.push_back(cfg_row(REG_REPEAT_LIMIT, 7'd1));
		dir_tab.push_back(cfg_row(REG_REPEAT_RELOAD, 7'd1));
		dir_tab.push_back(cfg_row(REG_EVENT_MAX, 7'd15));
		dir_tab.push_back(item_row(OP_TICK, 6'h3e));
		dir_tab.push_back(item_row(OP_TICK, 6'h3e));
		dir_tab.push_back(item_row(OP_COLLECT, 6'h15));
		dir_tab.push_back(cfg_row(REG_EVENT_MAX, 7'd1));
		dir_tab.push_back(item_row(OP_TICK, 6'h00));
		dir_tab.push_back(item_row(OP_TICK, 6'h00));
		dir_tab.push_back(collect_row(6'h3f, 1'b1, 24'h111111));
		dir_tab.push_back(cfg_row(REG_PRESS_THRESHOLD, 7'd0));
		dir_tab.push_back(cfg_row(REG_EVENT_MAX, 7'd0));
		dir_tab.push_back(item_row(OP_TICK, 6'h00));
		dir_tab.push_back(collect_row(6'h00, 1'b0, '0));

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		foreach (dir_tab[i]) begin
			if (dir_tab[i].is_cfg) begin
				if (!in_cfg) begin
					drain();
					in_cfg = 1'b1;
				end
				reg_write(dir_tab[i].idx, dir_tab[i].value);
			end else begin
				if (in_cfg) begin
					apb_idle();
					in_cfg = 1'b0;
				end
				send_request(dir_tab[i].op, dir_tab[i].levels, dir_tab[i].mark);
			end
		end

		run_phase(PRESS_THRESHOLD_RST, REPEAT_LIMIT_RST, REPEAT_RELOAD_RST, EVENT_MAX_RST, 190);
		run_phase(7'd1, 7'd1, 7'd1, 4'd15, 190);
		// stretch with no idling on either side
		calm = 1'b1;
		run_phase(7'd3, 7'd10, 7'd0, 4'd15, 190);
		calm = 1'b0;
		// no repeat, hold counter pinned at the top
		run_phase(7'd127, 7'd127, 7'd127, 4'd15, 190);
		run_phase(7'd0, 7'd0, 7'd0, 4'd0, 125);
		repeat (3)
			run_phase(7'($urandom_range(1, 15)), 7'($urandom_range(1, 30)),
				7'($urandom_range(0, 30)), 4'($urandom_range(1, 15)), 190);
		run_phase(7'($urandom), 7'($urandom), 7'($urandom), 4'($urandom), 125);

		drain();
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: button_debounce_autorepeat_unit.f
+incdir+hdl
hdl/bda_pkg.sv
hdl/bda_if.sv
hdl/bda_cfg.sv
hdl/bda_lane.sv
hdl/bda_merge.sv
hdl/button_debounce_autorepeat_unit.sv
tb/tb_button_debounce_autorepeat_unit.sv
